// ===== rtl/ga_linear_fitness_scaling_macros.svh =====
// Assertion macros shared by the linear fitness scaling RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef GA_LINEAR_FITNESS_SCALING_MACROS_SVH
`define GA_LINEAR_FITNESS_SCALING_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define LFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfs assertion failed");
// Antecedent implies consequent in the next cycle.
`define LFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfs assertion failed");
`else
`define LFS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LFS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lfs_pkg.sv =====
// Shared types and constants of the linear fitness scaling block.
// Used by every module of the block except lfs_ram; depends on nothing.
package lfs_pkg;

  localparam int OBJ_W  = 32;
  localparam int SUM_W  = 38;
  localparam int CNT_W  = 6;
  localparam int VAR_W  = 48;
  localparam int NUM_W  = 80;   // numerator and product width of the arithmetic unit
  localparam int DEN_W  = 44;   // divisor width
  localparam int MA_W   = 48;   // multiplicand width
  localparam int MB_W   = 32;   // multiplier width (one bit per cycle)
  localparam int SCL_W  = 16;
  localparam int TDATA_W = 232;

  localparam logic [SCL_W-1:0] Q12_ONE     = 16'd4096;
  localparam logic [SCL_W-1:0] SCALE_RESET = 16'd8192;
  localparam logic [OBJ_W-1:0] FIT_MAX     = 32'h7FFF_FFFF;
  localparam logic [VAR_W-1:0] VAR_MAX     = 48'hFFFF_FFFF_FFFF;

  localparam logic KIND_FITNESS = 1'b0;
  localparam logic KIND_STATS   = 1'b1;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } lfs_op_t;

  // Summary of one loaded pool, handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [OBJ_W-1:0] obj_min;
    logic signed [OBJ_W-1:0] obj_max;
    logic signed [SUM_W-1:0] obj_sum;
    logic                    ovf;
  } lfs_run_t;

  typedef struct packed {
    logic             start;
    lfs_op_t          op;
    logic [NUM_W-1:0] opa;
    logic [DEN_W-1:0] opb;
  } lfs_arith_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] result;
  } lfs_arith_rsp_t;

  typedef struct packed {
    logic                    kind;
    logic [CNT_W-1:0]        entry_index;
    logic signed [OBJ_W-1:0] fitness;
    logic signed [SUM_W-1:0] sum_fitness;
    logic signed [OBJ_W-1:0] mean_fitness;
    logic signed [OBJ_W-1:0] min_fitness;
    logic signed [OBJ_W-1:0] max_fitness;
    logic [CNT_W-1:0]        best_index;
    logic [VAR_W-1:0]        variance;
    logic                    overflowed;
    logic                    last;
  } lfs_result_t;

endpackage

// ===== rtl/lfs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lfs_front.sv =====
// Front end: accepts objective transactions, stores them and keeps running min, max and sum.
// Depends on lfs_pkg and the assertion macros; feeds a two-entry run queue to the back end.
`include "ga_linear_fitness_scaling_macros.svh"
module lfs_front import lfs_pkg::*; #(
  parameter int MAX_POOL = 32,
  localparam int AW = $clog2(MAX_POOL)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [OBJ_W-1:0]  in_tdata,
  input  logic              in_tlast,
  output logic              obj_we,
  output logic [AW-1:0]     obj_waddr,
  output logic [OBJ_W-1:0]  obj_wdata,
  output logic              run_valid,
  input  logic              run_ready,
  output lfs_run_t          run,
  input  logic              obj_free
);

  localparam int CW = $clog2(MAX_POOL + 1);

  logic [CW-1:0]           count_r;
  logic signed [OBJ_W-1:0] min_r, max_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    ovf_r;
  logic                    hold_r;
  lfs_run_t                q_mem_r [2];
  logic                    wptr_r, rptr_r;
  logic [1:0]              q_cnt_r;

  logic                    accept, push, pop, has_room;
  logic signed [OBJ_W-1:0] obj_c;
  logic [CW-1:0]           cnt_upd;
  logic signed [OBJ_W-1:0] min_upd, max_upd;
  logic signed [SUM_W-1:0] sum_upd;
  logic                    ovf_upd;
  lfs_run_t                run_new;

  // The store stays locked from the end of a pool until the back end has read it out.
  assign in_tready = !hold_r && (q_cnt_r != 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && in_tlast;
  assign pop       = run_valid && run_ready;
  assign has_room  = count_r < CW'(MAX_POOL);
  assign obj_c     = $signed(in_tdata);

  assign obj_we    = accept && has_room;
  assign obj_waddr = count_r[AW-1:0];
  assign obj_wdata = in_tdata;

  // Running statistics including the transaction being accepted.
  always_comb begin
    cnt_upd = count_r;
    min_upd = min_r;
    max_upd = max_r;
    sum_upd = sum_r;
    ovf_upd = ovf_r;
    if (has_room) begin
      cnt_upd = CW'(count_r + 1'b1);
      if (count_r == '0 || obj_c < min_r) begin
        min_upd = obj_c;
      end
      if (count_r == '0 || obj_c > max_r) begin
        max_upd = obj_c;
      end
      sum_upd = sum_r + SUM_W'(obj_c);
    end else begin
      ovf_upd = 1'b1;
    end
    run_new.count   = CNT_W'(cnt_upd);
    run_new.obj_min = min_upd;
    run_new.obj_max = max_upd;
    run_new.obj_sum = sum_upd;
    run_new.ovf     = ovf_upd;
  end

  // Accumulators, lock flag and run queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
      hold_r  <= 1'b0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (accept) begin
        if (in_tlast) begin
          count_r <= '0;
          min_r   <= '0;
          max_r   <= '0;
          sum_r   <= '0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= cnt_upd;
          min_r   <= min_upd;
          max_r   <= max_upd;
          sum_r   <= sum_upd;
          ovf_r   <= ovf_upd;
        end
      end
      if (obj_free) begin
        hold_r <= 1'b0;
      end
      if (push) begin
        hold_r            <= 1'b1;
        q_mem_r[wptr_r]   <= run_new;
        wptr_r            <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign run_valid = (q_cnt_r != 2'd0);
  assign run       = q_mem_r[rptr_r];

  `LFS_ASSERT_IMP(a_free_only_held, clk, rst_n, obj_free, hold_r)
  `LFS_ASSERT_IMP(a_queued_run_locks, clk, rst_n, run_valid, hold_r)
  `LFS_ASSERT_IMP(a_store_in_range, clk, rst_n, obj_we, count_r < CW'(MAX_POOL))

endmodule

// ===== rtl/lfs_arith.sv =====
// Shared arithmetic unit: bit-serial multiplier and restoring divider, one bit per cycle.
// Depends on lfs_pkg and the assertion macros.
`include "ga_linear_fitness_scaling_macros.svh"
module lfs_arith import lfs_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  lfs_arith_req_t req,
  output lfs_arith_rsp_t rsp
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic             busy_r, done_r;
  lfs_op_t          op_r;
  logic [STEP_W-1:0] cnt_r;
  logic [NUM_W-1:0] acc_r, ma_r;
  logic [MB_W-1:0]  mb_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [NUM_W-1:0] q_r;

  logic [DEN_W:0]   shifted;
  logic             ge;

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  assign shifted = {rem_r, q_r[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        acc_r  <= '0;
        ma_r   <= NUM_W'(req.opa[MA_W-1:0]);
        mb_r   <= req.opb[MB_W-1:0];
        rem_r  <= '0;
        den_r  <= req.opb;
        q_r    <= req.opa;
        cnt_r  <= (req.op == OP_MUL) ? STEP_W'(MB_W) : STEP_W'(NUM_W);
      end else if (busy_r) begin
        if (op_r == OP_MUL) begin
          if (mb_r[0]) begin
            acc_r <= acc_r + ma_r;
          end
          ma_r <= {ma_r[NUM_W-2:0], 1'b0};
          mb_r <= {1'b0, mb_r[MB_W-1:1]};
        end else begin
          rem_r <= ge ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
          q_r   <= {q_r[NUM_W-2:0], ge};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == OP_MUL) ? acc_r : q_r;

  `LFS_ASSERT_IMP(a_start_when_free, clk, rst_n, req.start, !busy_r && !done_r)

endmodule

// ===== rtl/lfs_back.sv =====
// Back end: per-pool sequencer for the scaling coefficients, fitness and statistics passes.
// Depends on lfs_pkg; uses lfs_arith through its request/response structs and both stores.
module lfs_back import lfs_pkg::*; #(
  parameter int MAX_POOL = 32,
  localparam int AW = $clog2(MAX_POOL)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [SCL_W-1:0] cfg_wr_data,
  input  logic             run_valid,
  output logic             run_ready,
  input  lfs_run_t         run,
  output logic             obj_free,
  output logic [AW-1:0]    obj_raddr,
  input  logic [OBJ_W-1:0] obj_rdata,
  output logic             fit_we,
  output logic [AW-1:0]    fit_waddr,
  output logic [OBJ_W-1:0] fit_wdata,
  output logic [AW-1:0]    fit_raddr,
  input  logic [OBJ_W-1:0] fit_rdata,
  output lfs_arith_req_t   arith_req,
  input  lfs_arith_rsp_t   arith_rsp,
  output logic             res_valid,
  input  logic             res_ready,
  output lfs_result_t      res
);

  typedef enum logic [4:0] {
    S_IDLE, S_MEAN, S_SM, S_LHS, S_DECIDE, S_K1, S_K2,
    S_RD, S_CALC, S_MUL1, S_ADDK, S_DIV1, S_EMIT,
    S_FMEAN, S_VRD, S_VCALC, S_VMUL, S_VDIV, S_STAT
  } state_t;

  state_t                  state_r;
  logic                    op_busy_r;
  logic [SCL_W-1:0]        scale_r;
  logic [CNT_W-1:0]        n_r, idx_r, best_r;
  logic signed [OBJ_W-1:0] min_r, max_r, mean_r, v_r, f_r;
  logic signed [SUM_W-1:0] sum_r, fsum_r;
  logic                    ovf_r, scale_on_r, pos_r;
  logic [OBJ_W-1:0]        delta_r, d_r;
  logic signed [47:0]      sm_r, lhs_r, k1_r;
  logic signed [49:0]      t_r;
  logic signed [NUM_W-1:0] k2_r;
  logic signed [NUM_W+1:0] num_r;
  logic signed [OBJ_W-1:0] fmin_r, fmax_r, fmean_r;
  logic [NUM_W-1:0]        acc_r;
  logic [VAR_W-1:0]        var_r;
  logic                    res_valid_r;
  lfs_result_t             res_r;

  logic                    slot_free, emit_fire, stat_fire, last_member;
  logic [SUM_W-1:0]        sum_mag, fsum_mag;
  logic [OBJ_W-1:0]        mean_mag, min_mag, v_mag, rd_mag;
  logic [47:0]             k1_mag;
  logic [49:0]             t_mag;
  logic [NUM_W+1:0]        num_mag;
  logic signed [49:0]      rhs_c;
  logic                    pos_c;
  logic signed [OBJ_W:0]   dpos_c, dneg_c, vdiff_c, vmin_c;
  logic signed [OBJ_W-1:0] rd_v, fit_v;
  logic [NUM_W-1:0]        q;

  assign q         = arith_rsp.result;
  assign slot_free = !res_valid_r || res_ready;
  assign emit_fire = (state_r == S_EMIT) && slot_free;
  assign stat_fire = (state_r == S_STAT) && slot_free;
  assign last_member = (CNT_W'(idx_r + 1'b1) == n_r);
  assign run_ready = (state_r == S_IDLE);
  assign obj_free  = emit_fire && last_member;

  assign obj_raddr = idx_r[AW-1:0];
  assign fit_raddr = idx_r[AW-1:0];
  assign fit_waddr = idx_r[AW-1:0];
  assign fit_wdata = f_r;
  assign fit_we    = emit_fire;

  // Magnitudes of the signed operands fed to the unsigned arithmetic unit.
  assign rd_v     = $signed(obj_rdata);
  assign fit_v    = $signed(fit_rdata);
  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign fsum_mag = fsum_r[SUM_W-1] ? SUM_W'(-fsum_r) : SUM_W'(fsum_r);
  assign mean_mag = mean_r[OBJ_W-1] ? OBJ_W'(-mean_r) : OBJ_W'(mean_r);
  assign min_mag  = min_r[OBJ_W-1] ? OBJ_W'(-min_r) : OBJ_W'(min_r);
  assign v_mag    = v_r[OBJ_W-1] ? OBJ_W'(-v_r) : OBJ_W'(v_r);
  assign rd_mag   = rd_v[OBJ_W-1] ? OBJ_W'(-rd_v) : OBJ_W'(rd_v);
  assign k1_mag   = k1_r[47] ? 48'(-k1_r) : 48'(k1_r);
  assign t_mag    = t_r[49] ? 50'(-t_r) : 50'(t_r);
  assign num_mag  = num_r[NUM_W+1] ? (NUM_W+2)'(-num_r) : (NUM_W+2)'(num_r);

  // Non-negative test of the scaling and the two possible spreads.
  assign rhs_c  = 50'(sm_r) - (50'(max_r) <<< 12);
  assign pos_c  = 50'(lhs_r) > rhs_c;
  assign dpos_c = (OBJ_W+1)'(max_r) - (OBJ_W+1)'(mean_r);
  assign dneg_c = (OBJ_W+1)'(mean_r) - (OBJ_W+1)'(min_r);
  assign vmin_c = (OBJ_W+1)'(v_r) - (OBJ_W+1)'(min_r);
  assign vdiff_c = (OBJ_W+1)'(fit_v) - (OBJ_W+1)'(fmean_r);

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    arith_req       = '0;
    arith_req.op    = OP_MUL;
    case (state_r)
      S_MEAN: begin
        arith_req.op  = OP_DIV;
        arith_req.opa = NUM_W'(sum_mag);
        arith_req.opb = DEN_W'(n_r);
      end
      S_SM: begin
        arith_req.opa = NUM_W'(scale_r);
        arith_req.opb = DEN_W'(mean_mag);
      end
      S_LHS: begin
        arith_req.opa = NUM_W'(SCL_W'(scale_r - Q12_ONE));
        arith_req.opb = DEN_W'(min_mag);
      end
      S_K1: begin
        arith_req.opa = NUM_W'(SCL_W'(scale_r - Q12_ONE));
        arith_req.opb = DEN_W'(mean_mag);
      end
      S_K2: begin
        arith_req.opa = NUM_W'(t_mag[MA_W-1:0]);
        arith_req.opb = DEN_W'(mean_mag);
      end
      S_MUL1: begin
        if (pos_r) begin
          arith_req.opa = NUM_W'(k1_mag);
          arith_req.opb = DEN_W'(v_mag);
        end else begin
          arith_req.opa = NUM_W'(vmin_c[OBJ_W-1:0]);
          arith_req.opb = DEN_W'(mean_mag);
        end
      end
      S_DIV1: begin
        arith_req.op  = OP_DIV;
        arith_req.opa = num_mag[NUM_W-1:0];
        arith_req.opb = pos_r ? DEN_W'({delta_r, 12'b0}) : DEN_W'(delta_r);
      end
      S_FMEAN: begin
        arith_req.op  = OP_DIV;
        arith_req.opa = NUM_W'(fsum_mag);
        arith_req.opb = DEN_W'(n_r);
      end
      S_VMUL: begin
        arith_req.opa = NUM_W'(d_r);
        arith_req.opb = DEN_W'(d_r);
      end
      S_VDIV: begin
        arith_req.op  = OP_DIV;
        arith_req.opa = acc_r;
        arith_req.opb = DEN_W'({n_r, 16'b0});
      end
      default: begin
        arith_req.op  = OP_MUL;
      end
    endcase
    case (state_r)
      S_MEAN, S_SM, S_LHS, S_K1, S_K2, S_MUL1, S_DIV1, S_FMEAN, S_VMUL, S_VDIV: begin
        arith_req.start = !op_busy_r;
      end
      default: begin
        arith_req.start = 1'b0;
      end
    endcase
  end

  // Sequencer, scale register and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_busy_r   <= 1'b0;
      scale_r     <= SCALE_RESET;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (arith_req.start) begin
        op_busy_r <= 1'b1;
      end
      if (arith_rsp.done) begin
        op_busy_r <= 1'b0;
      end
      // The output register fills on a fitness or statistics emit and empties when the receiver takes it.
      if (emit_fire || stat_fire) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (run_valid) begin
            n_r        <= run.count;
            min_r      <= run.obj_min;
            max_r      <= run.obj_max;
            sum_r      <= run.obj_sum;
            ovf_r      <= run.ovf;
            scale_on_r <= scale_r > Q12_ONE;
            idx_r      <= '0;
            fsum_r     <= '0;
            acc_r      <= '0;
            state_r    <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (arith_rsp.done) begin
            mean_r  <= sum_r[SUM_W-1] ? -$signed(q[OBJ_W-1:0]) : $signed(q[OBJ_W-1:0]);
            state_r <= scale_on_r ? S_SM : S_RD;
          end
        end
        S_SM: begin
          if (arith_rsp.done) begin
            sm_r    <= mean_r[OBJ_W-1] ? -$signed(q[47:0]) : $signed(q[47:0]);
            state_r <= S_LHS;
          end
        end
        S_LHS: begin
          if (arith_rsp.done) begin
            lhs_r   <= min_r[OBJ_W-1] ? -$signed(q[47:0]) : $signed(q[47:0]);
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pos_r   <= pos_c;
          delta_r <= pos_c ? dpos_c[OBJ_W-1:0] : dneg_c[OBJ_W-1:0];
          t_r     <= -rhs_c;
          state_r <= S_K1;
        end
        S_K1: begin
          if (arith_rsp.done) begin
            k1_r    <= mean_r[OBJ_W-1] ? -$signed(q[47:0]) : $signed(q[47:0]);
            state_r <= S_K2;
          end
        end
        S_K2: begin
          if (arith_rsp.done) begin
            k2_r    <= (mean_r[OBJ_W-1] ^ t_r[49]) ? -$signed(q) : $signed(q);
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          v_r <= rd_v;
          if (!scale_on_r) begin
            f_r     <= rd_v;
            state_r <= S_EMIT;
          end else if (delta_r == '0) begin
            // Zero spread: fitness is the saturated magnitude of the objective.
            f_r     <= (rd_mag > FIT_MAX) ? $signed(FIT_MAX) : $signed(rd_mag);
            state_r <= S_EMIT;
          end else begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (arith_rsp.done) begin
            if (pos_r ? (k1_r[47] ^ v_r[OBJ_W-1]) : mean_r[OBJ_W-1]) begin
              num_r <= -$signed({2'b00, q});
            end else begin
              num_r <= $signed({2'b00, q});
            end
            state_r <= S_ADDK;
          end
        end
        S_ADDK: begin
          if (pos_r) begin
            num_r <= num_r + (NUM_W+2)'(k2_r);
          end
          state_r <= S_DIV1;
        end
        S_DIV1: begin
          if (arith_rsp.done) begin
            f_r     <= (q > NUM_W'(FIT_MAX)) ? $signed(FIT_MAX) : $signed(q[OBJ_W-1:0]);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            res_r  <= '{kind: KIND_FITNESS, entry_index: idx_r, fitness: f_r, default: '0};
            fsum_r <= fsum_r + SUM_W'(f_r);
            if (idx_r == '0 || f_r > fmax_r) begin
              fmax_r <= f_r;
              best_r <= idx_r;
            end
            if (idx_r == '0 || f_r < fmin_r) begin
              fmin_r <= f_r;
            end
            if (last_member) begin
              idx_r   <= '0;
              state_r <= S_FMEAN;
            end else begin
              idx_r   <= CNT_W'(idx_r + 1'b1);
              state_r <= S_RD;
            end
          end
        end
        S_FMEAN: begin
          if (arith_rsp.done) begin
            fmean_r <= fsum_r[SUM_W-1] ? -$signed(q[OBJ_W-1:0]) : $signed(q[OBJ_W-1:0]);
            state_r <= S_VRD;
          end
        end
        S_VRD: begin
          state_r <= S_VCALC;
        end
        S_VCALC: begin
          d_r     <= vdiff_c[OBJ_W] ? OBJ_W'(-vdiff_c) : OBJ_W'(vdiff_c);
          state_r <= S_VMUL;
        end
        S_VMUL: begin
          if (arith_rsp.done) begin
            acc_r <= acc_r + q;
            if (last_member) begin
              state_r <= S_VDIV;
            end else begin
              idx_r   <= CNT_W'(idx_r + 1'b1);
              state_r <= S_VRD;
            end
          end
        end
        S_VDIV: begin
          if (arith_rsp.done) begin
            var_r   <= (q > NUM_W'(VAR_MAX)) ? VAR_MAX : q[VAR_W-1:0];
            state_r <= S_STAT;
          end
        end
        S_STAT: begin
          if (slot_free) begin
            res_r   <= '{kind: KIND_STATS, sum_fitness: fsum_r, mean_fitness: fmean_r,
                         min_fitness: fmin_r, max_fitness: fmax_r, best_index: best_r,
                         variance: var_r, overflowed: ovf_r, last: 1'b1, default: '0};
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/ga_linear_fitness_scaling.sv =====
// Linear fitness scaling over a pool of Q16.16 objectives. Objectives load at one transaction
// per cycle while the store is free. After the transaction flagged tlast, the back end runs
// a sequencer around one bit-serial multiplier and one restoring divider: a setup pass
// (shorter with scaling off), then a fitness pass per member (short with scaling off or at
// zero spread), then the fitness mean, a variance step per member and the final division.
// Fitness transactions come out in pool order, the statistics transaction last with tlast
// set. The next pool may start loading once the fitness pass of the previous one is done.
// No clearing pass is needed after reset.
// Depends on lfs_pkg, lfs_front, lfs_back, lfs_arith and lfs_ram.
module ga_linear_fitness_scaling import lfs_pkg::*; #(
  parameter int MAX_POOL = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [OBJ_W-1:0]   in_tdata,     // [31:0] objective
  input  logic               in_tlast,     // last_entry
  output logic               out_tvalid,
  input  logic               out_tready,
  // [5:0] entry_index, [37:6] fitness, [75:38] sum_fitness, [107:76] mean_fitness,
  // [139:108] min_fitness, [171:140] max_fitness, [177:172] best_index,
  // [225:178] variance, [226] overflowed, [231:227] zero
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tuser,    // result_kind
  output logic               out_tlast,    // last
  input  logic               cfg_wr_en,
  input  logic [SCL_W-1:0]   cfg_wr_data   // scale_factor
);

  localparam int AW = $clog2(MAX_POOL);

  logic             obj_we, fit_we, run_valid, run_ready, obj_free;
  logic [AW-1:0]    obj_waddr, obj_raddr, fit_waddr, fit_raddr;
  logic [OBJ_W-1:0] obj_wdata, obj_rdata, fit_wdata, fit_rdata;
  lfs_run_t         run;
  lfs_arith_req_t   arith_req;
  lfs_arith_rsp_t   arith_rsp;
  lfs_result_t      res;

  lfs_front #(.MAX_POOL(MAX_POOL)) u_front (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .obj_we, .obj_waddr, .obj_wdata,
    .run_valid, .run_ready, .run, .obj_free
  );

  lfs_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_POOL)) u_obj_ram (
    .clk, .we(obj_we), .waddr(obj_waddr), .wdata(obj_wdata),
    .raddr(obj_raddr), .rdata(obj_rdata)
  );

  lfs_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_POOL)) u_fit_ram (
    .clk, .we(fit_we), .waddr(fit_waddr), .wdata(fit_wdata),
    .raddr(fit_raddr), .rdata(fit_rdata)
  );

  lfs_arith u_arith (
    .clk, .rst_n, .req(arith_req), .rsp(arith_rsp)
  );

  lfs_back #(.MAX_POOL(MAX_POOL)) u_back (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .run_valid, .run_ready, .run, .obj_free,
    .obj_raddr, .obj_rdata,
    .fit_we, .fit_waddr, .fit_wdata, .fit_raddr, .fit_rdata,
    .arith_req, .arith_rsp,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  // Pack the result transaction onto the stream.
  assign out_tdata = {5'b0, res.overflowed, res.variance, res.best_index, res.max_fitness,
                      res.min_fitness, res.mean_fitness, res.sum_fitness, res.fitness,
                      res.entry_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== test/tb_ga_linear_fitness_scaling.sv =====
// Self-checking testbench for ga_linear_fitness_scaling: directed and random objective pools,
// a bit-exact scaling and statistics predictor, random idling on both streams and backpressure.
// Depends on lfs_pkg and the ga_linear_fitness_scaling RTL.
module tb_ga_linear_fitness_scaling;
  import lfs_pkg::*;

  localparam int POOL_CAP = 32;
  // Signed copy of 1.0 in Q4.12 so that predictor arithmetic stays signed.
  localparam longint Q12_ONE_L = longint'(Q12_ONE);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [OBJ_W-1:0]   in_tdata = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;
  logic               out_tlast;
  logic               cfg_wr_en = 1'b0;
  logic [SCL_W-1:0]   cfg_wr_data = '0;

  ga_linear_fitness_scaling #(.MAX_POOL(POOL_CAP)) dut (.*);

  always #6 clk = ~clk;

  // Predictor state: the stored pool, its running extremes and the scale register.
  logic signed [OBJ_W-1:0] pool_obj[POOL_CAP];
  int unsigned             pool_count = 0;
  longint                  pool_min = 0, pool_max = 0, pool_sum = 0;
  bit                      pool_dropped = 0;
  longint                  scale_reg = SCALE_RESET;

  lfs_result_t expected_results[$];
  int  error_count = 0;
  bit  idle_off = 0;
  int  hold_cycles = 0;

  // Works out every fitness transaction and the statistics transaction of a closed pool.
  task automatic predict_pool();
    longint mean, v, f, lhs, rhs, delta, fsum, fmin, fmax, fmean, d;
    logic signed [127:0] num, ta, tb, tc, td;
    logic [127:0] q, den, acc;
    longint fits[POOL_CAP];
    int unsigned best;
    bit pos;
    lfs_result_t r;
    mean = pool_count ? pool_sum / longint'(pool_count) : 0;
    fsum = 0; fmin = 0; fmax = 0; best = 0;
    for (int unsigned i = 0; i < pool_count; i++) begin
      v = pool_obj[i];
      f = v;
      if (scale_reg > Q12_ONE_L) begin
        lhs = pool_min * (scale_reg - Q12_ONE_L);
        rhs = scale_reg * mean - pool_max * Q12_ONE_L;
        pos = lhs > rhs;
        delta = pos ? pool_max - mean : mean - pool_min;
        if (delta == 0) begin
          f = (v < 0) ? -v : v;
          if (f > FIT_MAX) f = FIT_MAX;
        end else begin
          if (pos) begin
            ta = (scale_reg - Q12_ONE_L) * mean;
            tb = v;
            tc = mean;
            td = pool_max * Q12_ONE_L - scale_reg * mean;
            num = ta * tb + tc * td;
            den = delta * Q12_ONE_L;
          end else begin
            ta = mean;
            tb = v - pool_min;
            num = ta * tb;
            den = delta;
          end
          if (num < 0) num = -num;
          q = num / den;
          f = (q > FIT_MAX) ? FIT_MAX : longint'(q);
        end
      end
      fits[i] = f;
      fsum += f;
      if (i == 0 || f > fmax) begin
        fmax = f;
        best = i;
      end
      if (i == 0 || f < fmin) fmin = f;
      r = '0;
      r.kind = KIND_FITNESS;
      r.entry_index = CNT_W'(i);
      r.fitness = OBJ_W'(f);
      expected_results.push_back(r);
    end
    r = '0;
    if (pool_count) begin
      fmean = fsum / longint'(pool_count);
      acc = 0;
      for (int unsigned i = 0; i < pool_count; i++) begin
        d = fits[i] - fmean;
        if (d < 0) d = -d;
        acc += 128'(d) * 128'(d);
      end
      q = acc / (128'(pool_count) << 16);
      r.variance = (q > VAR_MAX) ? VAR_MAX : q[VAR_W-1:0];
      r.sum_fitness = SUM_W'(fsum);
      r.mean_fitness = OBJ_W'(fmean);
      r.min_fitness = OBJ_W'(fmin);
      r.max_fitness = OBJ_W'(fmax);
      r.best_index = CNT_W'(best);
    end
    r.kind = KIND_STATS;
    r.overflowed = pool_dropped;
    r.last = 1'b1;
    expected_results.push_back(r);
    pool_count = 0; pool_min = 0; pool_max = 0; pool_sum = 0; pool_dropped = 0;
  endtask

  task automatic model_member(logic signed [OBJ_W-1:0] obj, bit closes);
    if (pool_count < POOL_CAP) begin
      pool_obj[pool_count] = obj;
      if (pool_count == 0 || obj < pool_min) pool_min = obj;
      if (pool_count == 0 || obj > pool_max) pool_max = obj;
      pool_sum += obj;
      pool_count++;
    end else begin
      pool_dropped = 1;
    end
    if (closes) predict_pool();
  endtask

  // Sends one member; valid stays high into the next call unless that call idles.
  task automatic send_member(logic [OBJ_W-1:0] obj, bit closes);
    if (!idle_off && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= obj;
    in_tlast <= closes;
    do @(posedge clk); while (!in_tready);
    model_member(obj, closes);
  endtask

  task automatic send_pool(logic [OBJ_W-1:0] objs[$]);
    foreach (objs[i]) send_member(objs[i], i == objs.size() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_scale(logic [SCL_W-1:0] val);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale_reg = val;
  endtask

  function automatic logic [OBJ_W-1:0] rand_obj();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000F_FFFF);
      2: return -$urandom_range(0, 32'h000F_FFFF);
      default: return $urandom_range(0, 32'h7FF) - 32'h400;
    endcase
  endfunction

  task automatic test_copy_mode();
    set_scale(Q12_ONE);
    send_pool('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000});
    send_pool('{32'h1234_5678});
  endtask

  task automatic test_scaling_reset_value();
    send_pool('{32'h0001_0000, 32'h0002_0000, 32'h0004_0000});
    send_pool('{32'h8000_0000, 32'h7FFF_FFFF});
    send_pool('{-32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
  endtask

  task automatic test_zero_spread();
    set_scale(16'd4097);
    send_pool('{32'h8000_0000, 32'h8000_0000});
    send_pool('{-32'h5000, -32'h5000, -32'h5000});
  endtask

  task automatic test_scale_extremes();
    set_scale(16'hFFFF);
    send_pool('{32'h0000_1000, 32'h0100_0000, -32'h0000_2000, 32'h7FFF_FFFF});
    set_scale(16'd0);
    send_pool('{32'h0000_0001, 32'hFFFF_FFFE});
  endtask

  // A pool larger than the store; the dropped member carries the last flag.
  task automatic test_pool_overflow();
    logic [OBJ_W-1:0] objs[$];
    set_scale(SCALE_RESET);
    for (int i = 0; i < POOL_CAP + 2; i++) objs.push_back(rand_obj());
    send_pool(objs);
  endtask

  // The receiver holds off while several pools are offered, so the block stalls its input.
  task automatic test_backpressure();
    logic [OBJ_W-1:0] objs[$];
    wait_drained();
    hold_cycles = 600;
    for (int p = 0; p < 3; p++) begin
      objs = {};
      for (int i = 0; i < 6; i++) objs.push_back(rand_obj());
      send_pool(objs);
    end
    wait_drained();
  endtask

  task automatic test_random_pools();
    logic [OBJ_W-1:0] objs[$];
    logic [SCL_W-1:0] scales[6] = '{16'd0, 16'd4096, 16'd4097, 16'd8192, 16'hFFFF, 16'd0};
    int sent = 0;
    while (sent < 120) begin
      if ($urandom_range(3) == 0) begin
        scales[5] = $urandom;
        set_scale(scales[$urandom_range(5)]);
      end
      idle_off = ($urandom_range(7) == 0);
      objs = {};
      repeat ($urandom_range(9) == 0 ? $urandom_range(20, POOL_CAP + 2) : $urandom_range(1, 8))
        objs.push_back(rand_obj());
      send_pool(objs);
      sent += objs.size();
    end
    idle_off = 0;
  endtask

  // Receiver ready, with random idling and the long hold.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= idle_off || $urandom_range(99) >= 13;
    end
  end

  function automatic void check_field(string nm, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch %s: expected %h, got %h", nm, exp_v, act_v);
    end
  endfunction

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    lfs_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result transaction");
      end else begin
        e = expected_results.pop_front();
        check_field("result_kind", e.kind, out_tuser);
        check_field("entry_index", e.entry_index, out_tdata[5:0]);
        check_field("fitness", $unsigned(e.fitness), out_tdata[37:6]);
        check_field("sum_fitness", $unsigned(e.sum_fitness), out_tdata[75:38]);
        check_field("mean_fitness", $unsigned(e.mean_fitness), out_tdata[107:76]);
        check_field("min_fitness", $unsigned(e.min_fitness), out_tdata[139:108]);
        check_field("max_fitness", $unsigned(e.max_fitness), out_tdata[171:140]);
        check_field("best_index", e.best_index, out_tdata[177:172]);
        check_field("variance", e.variance, out_tdata[225:178]);
        check_field("overflowed", e.overflowed, out_tdata[226]);
        check_field("last", e.last, out_tlast);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_scaling_reset_value();
    test_copy_mode();
    test_zero_spread();
    test_scale_extremes();
    test_pool_overflow();
    test_backpressure();
    test_random_pools();
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
